@@ sv/aes_cbc_pkg.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_pkg
// Shared types, constants and the AES substitution table for the AES-128
// CBC encryption block.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

  // Field and block widths.
  localparam int DATA_W      = 64;
  localparam int COUNT_W     = 5;
  localparam int BLOCK_W     = 128;
  localparam int BLOCK_BYTES = 16;
  localparam int NUM_ROUNDS  = 10;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_IV_HIGH  = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IV_LOW   = 4'd3;

  // A block made only of padding: sixteen bytes of value sixteen.
  localparam logic [BLOCK_W-1:0] PAD_FULL_BLOCK = {BLOCK_BYTES{8'h10}};

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [NUM_ROUNDS:0][BLOCK_W-1:0] round_keys_t;

  // Forward substitution box.
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

endpackage

@@ sv/aes_cbc_in_if.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_in_if
// Plaintext channel: one 16-byte block per word with its framing flags.
// ----------------------------------------------------------------------------
interface aes_cbc_in_if;
  import aes_cbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  plain_high;
  logic [DATA_W-1:0]  plain_low;
  logic [COUNT_W-1:0] byte_count;
  logic               last_block;
  logic               new_message;

  modport source (
    output valid, plain_high, plain_low, byte_count, last_block, new_message,
    input  ready
  );

  modport sink (
    input  valid, plain_high, plain_low, byte_count, last_block, new_message,
    output ready
  );
endinterface

@@ sv/aes_cbc_out_if.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_out_if
// Ciphertext channel: one 16-byte block per word and an end-of-message flag.
// ----------------------------------------------------------------------------
interface aes_cbc_out_if;
  import aes_cbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cipher_high;
  logic [DATA_W-1:0] cipher_low;
  logic              last_result;

  modport source (
    output valid, cipher_high, cipher_low, last_result,
    input  ready
  );

  modport sink (
    input  valid, cipher_high, cipher_low, last_result,
    output ready
  );
endinterface

@@ sv/aes_cbc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_cfg_if
// Register write channel: a register index and a 64-bit data word.
// ----------------------------------------------------------------------------
interface aes_cbc_cfg_if;
  import aes_cbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [DATA_W-1:0]     data;

  modport source (
    output valid, addr, data,
    input  ready
  );

  modport sink (
    input  valid, addr, data,
    output ready
  );
endinterface

@@ sv/aes128_cbc_encrypt.sv @@
// ----------------------------------------------------------------------------
// aes128_cbc_encrypt
// AES-128 CBC encryption with PKCS#7 padding of the last block of a message.
// ----------------------------------------------------------------------------
// Each plaintext word is padded on entry, held in a work register, chained
// with the previous ciphertext (or the IV when new_message is set) and run
// through all ten AES rounds combinationally into the output register. A block
// is accepted every cycle while the output is taken; a plaintext word is first
// registered in the work register, and its ciphertext is loaded into the
// output register when it fires, once the output register is free.
// A last block with sixteen valid bytes produces two words, the block and
// then a full padding block, so it stays in the work register for a second
// pass and holds off the next plaintext word meanwhile. The rate is set by the
// combinational ten-round cipher feeding its result back as the next chaining
// value. An IV write is in use for a block that enters the cipher after the
// IV register has taken it; a key write only once the round key register has
// taken it too, since the round keys are registered.
module aes128_cbc_encrypt (
  input  logic          clk,
  input  logic          rst,
  aes_cbc_in_if.sink    plain_in,
  aes_cbc_out_if.source cipher_out,
  aes_cbc_cfg_if.sink   cfg
);
  import aes_cbc_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] key_high, key_low, iv_high, iv_low;

  // Work register: one padded block waiting for the cipher.
  logic   work_valid;
  block_t work_block;
  logic   work_fresh;
  logic   work_last;
  logic   work_extra;

  // Chaining value and output register.
  block_t chain;
  logic   out_valid;
  block_t out_block;
  logic   out_last;

  // Entry padding.
  logic [COUNT_W-1:0] count_sat;
  logic               pad_on;
  logic [7:0]         pad_val;
  block_t             plain_block;
  block_t             padded_block;

  round_keys_t round_keys;
  block_t      cipher_in;
  block_t      cipher_res;
  logic        out_free;
  logic        fire;
  logic        accept;

  // Register writes; indexes beyond the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      iv_high  <= '0;
      iv_low   <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_KEY_HIGH: key_high <= cfg.data;
        REG_KEY_LOW:  key_low  <= cfg.data;
        REG_IV_HIGH:  iv_high  <= cfg.data;
        REG_IV_LOW:   iv_low   <= cfg.data;
        default: ;
      endcase
    end
  end

  aes_cbc_key_exp u_key_exp (
    .clk        (clk),
    .key        ({key_high, key_low}),
    .round_keys (round_keys)
  );

  // Fill the bytes past byte_count of a short last block with the pad value.
  assign count_sat   = (plain_in.byte_count > COUNT_W'(BLOCK_BYTES)) ?
                       COUNT_W'(BLOCK_BYTES) : plain_in.byte_count;
  assign pad_on      = plain_in.last_block && (count_sat < COUNT_W'(BLOCK_BYTES));
  assign pad_val     = 8'(COUNT_W'(BLOCK_BYTES) - count_sat);
  assign plain_block = {plain_in.plain_high, plain_in.plain_low};

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (pad_on && (COUNT_W'(i) >= count_sat)) begin
        padded_block[8*(15 - i) +: 8] = pad_val;
      end else begin
        padded_block[8*(15 - i) +: 8] = plain_block[8*(15 - i) +: 8];
      end
    end
  end

  // Handshake: the cipher fires when the output register can take a word.
  assign out_free       = !out_valid || cipher_out.ready;
  assign fire           = work_valid && out_free;
  assign plain_in.ready = !work_valid || (fire && !work_extra);
  assign accept         = plain_in.valid && plain_in.ready;

  // Work register. A full last block stays for a second pass with padding.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else begin
      priority if (accept) begin
        work_valid <= 1'b1;
      end else if (fire && !work_extra) begin
        work_valid <= 1'b0;
      end else begin
        work_valid <= work_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (accept) begin
      work_block <= padded_block;
      work_fresh <= plain_in.new_message;
      work_last  <= pad_on;
      work_extra <= plain_in.last_block && !pad_on;
    end else if (fire && work_extra) begin
      work_block <= PAD_FULL_BLOCK;
      work_fresh <= 1'b0;
      work_last  <= 1'b1;
      work_extra <= 1'b0;
    end else begin
      work_block <= work_block;
      work_fresh <= work_fresh;
      work_last  <= work_last;
      work_extra <= work_extra;
    end
  end

  // CBC chaining and the cipher.
  assign cipher_in = work_block ^ (work_fresh ? {iv_high, iv_low} : chain);

  aes_cbc_cipher u_cipher (
    .data_in    (cipher_in),
    .round_keys (round_keys),
    .data_out   (cipher_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (fire) begin
      chain <= cipher_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (cipher_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_block <= cipher_res;
      out_last  <= work_last;
    end
  end

  assign cipher_out.valid       = out_valid;
  assign cipher_out.cipher_high = out_block[BLOCK_W-1:DATA_W];
  assign cipher_out.cipher_low  = out_block[DATA_W-1:0];
  assign cipher_out.last_result = out_last;

endmodule

@@ sv/aes_cbc_key_exp.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_key_exp
// AES-128 key schedule. Expands the cipher key into eleven round keys and
// holds them in a register, so a new key is in use once the round key
// register has taken it.
// ----------------------------------------------------------------------------
module aes_cbc_key_exp (
  input  logic                      clk,
  input  aes_cbc_pkg::block_t       key,
  output aes_cbc_pkg::round_keys_t  round_keys
);
  import aes_cbc_pkg::*;

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  round_keys_t round_keys_next;

  // Round zero is the key itself.
  assign round_keys_next[0] = key;

  // Each later round key follows from the one before it.
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;

    assign w0 = round_keys_next[r-1][127:96];
    assign w1 = round_keys_next[r-1][95:64];
    assign w2 = round_keys_next[r-1][63:32];
    assign w3 = round_keys_next[r-1][31:0];

    // Rotate the last word by one byte, substitute and add the round constant.
    assign t = {SBOX[w3[23:16]] ^ RCON[r-1], SBOX[w3[15:8]], SBOX[w3[7:0]],
                SBOX[w3[31:24]]};

    assign n0 = w0 ^ t;
    assign n1 = w1 ^ n0;
    assign n2 = w2 ^ n1;
    assign n3 = w3 ^ n2;

    assign round_keys_next[r] = {n0, n1, n2, n3};
  end

  // Round key register.
  always_ff @(posedge clk) begin
    round_keys <= round_keys_next;
  end

endmodule

@@ sv/aes_cbc_cipher.sv @@
// ----------------------------------------------------------------------------
// aes_cbc_cipher
// AES-128 forward cipher, all ten rounds unrolled. Bytes are taken in
// column-major order, byte 0 in the top bits of the block.
// ----------------------------------------------------------------------------
module aes_cbc_cipher (
  input  aes_cbc_pkg::block_t      data_in,
  input  aes_cbc_pkg::round_keys_t round_keys,
  output aes_cbc_pkg::block_t      data_out
);
  import aes_cbc_pkg::*;

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // One round: SubBytes, ShiftRows, MixColumns (skipped in the last round)
  // and AddRoundKey.
  function automatic block_t enc_round(block_t s, block_t k, logic last_rnd);
    logic [7:0] t [BLOCK_BYTES];
    logic [7:0] a0, a1, a2, a3, all_x;
    block_t     res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4 + r] = SBOX[s[8*(15 - (((c + r) % 4)*4 + r)) +: 8]];
      end
    end
    if (!last_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4 + 1];
        a2 = t[c*4 + 2];
        a3 = t[c*4 + 3];
        all_x = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]     = a0 ^ all_x ^ xtime(a0 ^ a1);
        t[c*4 + 1] = a1 ^ all_x ^ xtime(a1 ^ a2);
        t[c*4 + 2] = a2 ^ all_x ^ xtime(a2 ^ a3);
        t[c*4 + 3] = a3 ^ all_x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      res[8*(15 - i) +: 8] = t[i] ^ k[8*(15 - i) +: 8];
    end
    return res;
  endfunction

  block_t state [NUM_ROUNDS+1];

  // Initial key addition.
  assign state[0] = data_in ^ round_keys[0];

  // Round chain.
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    assign state[r] = enc_round(state[r-1], round_keys[r], r == NUM_ROUNDS);
  end

  assign data_out = state[NUM_ROUNDS];

endmodule
